### rtl/phf_pkg.sv
// Shared types, constants and helpers for the packet header/payload FNV-1a hasher.
package phf_pkg;

    localparam logic [63:0] FNV_BASIS   = 64'hCBF2_9CE4_8422_2325;
    localparam logic [3:0]  HDR_FIELDS  = 4'd11;
    localparam int          QUEUE_DEPTH_DEF = 4;

    localparam logic [1:0] OP_HDR = 2'd0;
    localparam logic [1:0] OP_PAY = 2'd1;
    localparam logic [1:0] OP_FIN = 2'd2;
    localparam logic [1:0] OP_NOP = 2'd3;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_LEN = 2'd1;
    localparam logic [1:0] ST_SEQ = 2'd2;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [63:0] value;
    } t_in;

    typedef struct packed {
        logic [63:0] hash;
        logic [1:0]  status;
    } t_out;

    typedef enum logic {
        CMD_ABSORB = 1'b0,
        CMD_FINISH = 1'b1
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind   kind;
        logic [2:0]  last_byte;
        logic [63:0] data;
        logic [1:0]  status;
    } t_cmd;

    // index of the last little-endian byte absorbed for a header field
    function automatic logic [2:0] field_last_byte(input logic [3:0] idx);
        logic [2:0] lb;
        unique case (idx)
            4'd2, 4'd3:  lb = 3'd1;
            4'd9, 4'd10: lb = 3'd3;
            default:     lb = 3'd7;
        endcase
        return lb;
    endfunction

    // one FNV-1a byte step; prime is 2^40 + 2^8 + 2^7 + 2^5 + 2^4 + 2^1 + 1
    function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
        logic [63:0] x;
        x = h ^ {56'd0, b};
        return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
    endfunction

endpackage

### rtl/phf_front.sv
// Front end: accepts items, tracks header order and byte count, queues commands.
module phf_front
    import phf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_data,
    input  logic i_q_full,
    output logic o_push,
    output t_cmd o_push_cmd
);

    logic [3:0]  r_idx, n_idx;
    logic [31:0] r_len, n_len;
    logic [31:0] r_cnt, n_cnt;
    logic        r_err, n_err;
    logic        accept;

    assign accept     = i_in_valid && !i_q_full;
    assign o_in_stall = i_q_full;

    always_comb begin
        n_idx = r_idx;
        n_len = r_len;
        n_cnt = r_cnt;
        n_err = r_err;
        o_push = 1'b0;
        o_push_cmd.kind      = CMD_ABSORB;
        o_push_cmd.last_byte = 3'd0;
        o_push_cmd.data      = i_in_data.value;
        o_push_cmd.status    = ST_OK;
        if (accept) begin
            unique case (i_in_data.opcode)
                OP_HDR: begin
                    if (r_idx < HDR_FIELDS) begin
                        o_push = 1'b1;
                        o_push_cmd.last_byte = field_last_byte(r_idx);
                        if (r_idx == HDR_FIELDS - 4'd1) begin
                            n_len = i_in_data.value[31:0];
                        end
                        n_idx = r_idx + 4'd1;
                    end else begin
                        n_err = 1'b1;
                    end
                end
                OP_PAY: begin
                    if (r_idx == HDR_FIELDS) begin
                        o_push = 1'b1;
                        if (r_cnt != 32'hFFFF_FFFF) begin
                            n_cnt = r_cnt + 32'd1;
                        end
                    end else begin
                        n_err = 1'b1;
                    end
                end
                OP_FIN: begin
                    o_push = 1'b1;
                    o_push_cmd.kind = CMD_FINISH;
                    if (r_err || r_idx != HDR_FIELDS) begin
                        o_push_cmd.status = ST_SEQ;
                    end else if (r_cnt != r_len) begin
                        o_push_cmd.status = ST_LEN;
                    end
                    n_idx = 4'd0;
                    n_len = 32'd0;
                    n_cnt = 32'd0;
                    n_err = 1'b0;
                end
                OP_NOP: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 4'd0;
            r_len <= 32'd0;
            r_cnt <= 32'd0;
            r_err <= 1'b0;
        end else begin
            r_idx <= n_idx;
            r_len <= n_len;
            r_cnt <= n_cnt;
            r_err <= n_err;
        end
    end

endmodule

### rtl/phf_queue.sv
// Command queue between the front end and the hashing back end.
module phf_queue
    import phf_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_push_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_head
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wr, n_wr;
    logic [PW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_push_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DEPTH))
        else $error("queue count beyond depth");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("command pushed into full queue");

endmodule

### rtl/phf_back.sv
// Back end: absorbs queued bytes into the running hash and emits finished results.
module phf_back
    import phf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_q_valid,
    input  t_cmd i_q_head,
    output logic o_pop,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data
);

    logic [63:0] r_hash, n_hash;
    logic [2:0]  r_idx, n_idx;
    logic        r_out_valid, n_out_valid;
    t_out        r_out, n_out;
    logic        out_free;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        n_hash      = r_hash;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        o_pop       = 1'b0;
        if (i_q_valid) begin
            unique case (i_q_head.kind)
                CMD_ABSORB: begin
                    n_hash = fnv_step(r_hash, i_q_head.data[{r_idx, 3'b000} +: 8]);
                    if (r_idx == i_q_head.last_byte) begin
                        o_pop = 1'b1;
                        n_idx = 3'd0;
                    end else begin
                        n_idx = r_idx + 3'd1;
                    end
                end
                CMD_FINISH: begin
                    if (out_free) begin
                        o_pop        = 1'b1;
                        n_out_valid  = 1'b1;
                        n_out.hash   = (i_q_head.status == ST_OK) ? r_hash : 64'd0;
                        n_out.status = i_q_head.status;
                        n_hash       = FNV_BASIS;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash      <= FNV_BASIS;
            r_idx       <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_hash      <= n_hash;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    a_finish_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_q_head.kind == CMD_FINISH) |=>
            (r_out_valid && (r_out.status == ST_OK || r_out.hash == 64'd0)))
        else $error("finish did not load a consistent result");

    a_mid_field_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_idx != 3'd0) |-> (i_q_valid && i_q_head.kind == CMD_ABSORB))
        else $error("byte index advanced without an absorb at the head");

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_idx != 3'd0) |-> (r_idx <= i_q_head.last_byte))
        else $error("byte index past the end of the field");

endmodule

### rtl/packet_header_payload_fnv1a64_core.sv
// Top level of the packet header/payload FNV-1a 64 hasher.
// The front end takes one item per cycle while its command queue (QUEUE_DEPTH
// entries) has room; the back end folds one byte per cycle into the hash while
// a command is queued, a header field being 2, 4 or 8 bytes and a payload item
// a single byte, and a finish waits until the output register is free. The
// single byte-wide FNV step in the back end thus sets sustained throughput,
// with bursts absorbed by the queue. A result is loaded into the output
// register once its finish command is at the head of the queue and that
// register is free, and is held there until the transfer completes.
module packet_header_payload_fnv1a64_core
    import phf_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data
);

    logic q_full;
    logic q_push;
    t_cmd q_push_cmd;
    logic q_pop;
    logic q_valid;
    t_cmd q_head;

    phf_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_q_full   (q_full),
        .o_push     (q_push),
        .o_push_cmd (q_push_cmd)
    );

    phf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (q_push),
        .i_push_cmd (q_push_cmd),
        .o_full     (q_full),
        .i_pop      (q_pop),
        .o_valid    (q_valid),
        .o_head     (q_head)
    );

    phf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_head    (q_head),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
